>>> rtl/lci_pkg.sv
// ----------------------------------------------------------------------------
// lci_pkg: shared types and constants for the line and circle intersection
// block.
// Holds the item structs, the status codes, the width constants and the
// handover record that passes from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package lci_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned InFracBits  = 4;
  localparam int unsigned OutFracBits = 16;
  localparam int unsigned ScaleK      = OutFracBits - InFracBits;
  localparam int unsigned OutBits     = 32;

  // Widths of the exact intermediate values.
  localparam int unsigned DiffBits = CoordBits + 1;   // e and u components
  localparam int unsigned DotBits  = 2 * DiffBits + 1; // X, Y and U
  localparam int unsigned DiscBits = 2 * DotBits + 2;  // discriminant d
  localparam int unsigned BaseBits = DotBits + DiffBits + CoordBits + 1;
  localparam int unsigned RadBits  = (DiscBits + 2 * ScaleK + 1) / 2 + 1;
  localparam int unsigned NumBits  = CoordBits + DotBits + ScaleK + 3;

  // Pipeline depths of the iterative back-end units. The divider walks every
  // bit of its dividend, so it needs one step per dividend bit.
  localparam int unsigned SqrtSteps = (DiscBits + 2 * ScaleK + 1) / 2;
  localparam int unsigned QuotBits  = NumBits + 1;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    StatusTwoPoints  = 2'd0,
    StatusNoCross    = 2'd1,
    StatusDegenerate = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic        [CoordBits-2:0] radius;
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]         status;
    logic signed [OutBits-1:0] near_x;
    logic signed [OutBits-1:0] near_y;
    logic signed [OutBits-1:0] far_x;
    logic signed [OutBits-1:0] far_y;
  } out_item_t;

  // Classified query as it leaves the front part.
  typedef struct packed {
    status_e                    status;
    logic        [DiscBits-1:0] disc;
    logic        [DotBits-1:0]  dot_ee;
    logic signed [BaseBits-1:0] base_x;
    logic signed [BaseBits-1:0] base_y;
    logic signed [DiffBits-1:0] dir_x;
    logic signed [DiffBits-1:0] dir_y;
  } job_t;

endpackage : lci_pkg

`default_nettype wire

>>> rtl/lci_front.sv
// ----------------------------------------------------------------------------
// lci_front: front part of the intersection block.
// Forms the exact dot products and the discriminant in a short pipeline and
// classifies each query before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  input  lci_pkg::in_item_t        in_item_i,
  input  wire                logic advance_i,
  output logic                     out_valid_o,
  output lci_pkg::job_t            out_job_o
);
  import lci_pkg::*;

  typedef logic signed [DiffBits-1:0] diff_t;
  typedef logic signed [DotBits-1:0]  dot_t;

  // Stage one: differences and dot products.
  logic        s1_valid_q;
  dot_t        xd_q, yd_q, ud_q;
  logic [2*CoordBits-3:0] rr_q;
  diff_t       ex_q, ey_q;
  logic signed [CoordBits-1:0] x1_q, y1_q;

  // Stage two: discriminant and the unscaled foot numerators.
  logic        s2_valid_q;
  job_t        job_q;

  diff_t ex_d, ey_d, ux_d, uy_d;
  logic signed [2*DotBits+1:0] disc_full;
  logic signed [DotBits:0]     u_minus_r;

  assign ex_d = diff_t'(in_item_i.second_x) - diff_t'(in_item_i.first_x);
  assign ey_d = diff_t'(in_item_i.second_y) - diff_t'(in_item_i.first_y);
  assign ux_d = diff_t'(in_item_i.first_x) - diff_t'(in_item_i.center_x);
  assign uy_d = diff_t'(in_item_i.first_y) - diff_t'(in_item_i.center_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      xd_q <= dot_t'(ux_d * ex_d) + dot_t'(uy_d * ey_d);
      yd_q <= dot_t'(ex_d * ex_d) + dot_t'(ey_d * ey_d);
      ud_q <= dot_t'(ux_d * ux_d) + dot_t'(uy_d * uy_d);
      rr_q <= in_item_i.radius * in_item_i.radius;
      ex_q <= ex_d;
      ey_q <= ey_d;
      x1_q <= in_item_i.first_x;
      y1_q <= in_item_i.first_y;
    end
  end

  assign u_minus_r = (DotBits+1)'(ud_q) - (DotBits+1)'($signed({1'b0, rr_q}));
  assign disc_full = (2*DotBits+2)'(xd_q * xd_q)
                   - (2*DotBits+2)'(yd_q * u_minus_r);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (yd_q == '0) begin
        job_q.status <= StatusDegenerate;
      end else if (disc_full < 0) begin
        job_q.status <= StatusNoCross;
      end else begin
        job_q.status <= StatusTwoPoints;
      end
      job_q.disc   <= DiscBits'(disc_full);
      job_q.dot_ee <= yd_q;
      job_q.base_x <= BaseBits'(x1_q * yd_q) - BaseBits'(ex_q * xd_q);
      job_q.base_y <= BaseBits'(y1_q * yd_q) - BaseBits'(ey_q * xd_q);
      job_q.dir_x  <= ex_q;
      job_q.dir_y  <= ey_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_job_o   = job_q;

endmodule : lci_front

`default_nettype wire

>>> rtl/lci_queue.sv
// ----------------------------------------------------------------------------
// lci_queue: small first-in first-out queue between the front and the back.
// Register based; one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  lci_pkg::job_t   push_job_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output lci_pkg::job_t   pop_job_o
);
  import lci_pkg::*;

  job_t                 slot_q [QueueDepth];
  logic [QueueIdxW-1:0] wr_q, rd_q;
  logic [QueueIdxW:0]   count_q;

  assign full_o    = (count_q == (QueueIdxW+1)'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_job_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      count_q <= count_q + (QueueIdxW+1)'(push_i) - (QueueIdxW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_job_i;
  end

endmodule : lci_queue

`default_nettype wire

>>> rtl/lci_back.sv
// ----------------------------------------------------------------------------
// lci_back: back part of the intersection block.
// A pipelined square root (one result bit per stage) is followed by the
// offset products and a pipelined restoring divider per coordinate, then
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  lci_pkg::job_t    in_job_i,
  input  wire logic        advance_i,
  output logic             out_valid_o,
  output lci_pkg::out_item_t out_item_o
);
  import lci_pkg::*;

  localparam int unsigned RadW  = 2 * SqrtSteps + 2;
  localparam int unsigned DivW  = NumBits + 1;

  typedef struct packed {
    status_e                    status;
    logic        [DotBits-1:0]  dot_ee;
    logic signed [DotBits+DiffBits+CoordBits:0] base_x;
    logic signed [DotBits+DiffBits+CoordBits:0] base_y;
    logic signed [DiffBits-1:0] dir_x;
    logic signed [DiffBits-1:0] dir_y;
  } carry_t;

  // ---- square root pipeline ----
  logic              sq_v_q   [SqrtSteps+1];
  logic [RadW-1:0]   sq_n_q   [SqrtSteps+1];
  logic [RadW-1:0]   sq_res_q [SqrtSteps+1];
  carry_t            sq_c_q   [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SqrtSteps; i++) sq_v_q[i] <= 1'b0;
    end else if (advance_i) begin
      sq_v_q[0] <= in_valid_i;
      for (int i = 1; i <= SqrtSteps; i++) sq_v_q[i] <= sq_v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sq_n_q[0]   <= RadW'(in_job_i.disc) << (2 * ScaleK);
      sq_res_q[0] <= '0;
      sq_c_q[0]   <= '{in_job_i.status, in_job_i.dot_ee, in_job_i.base_x,
                       in_job_i.base_y, in_job_i.dir_x, in_job_i.dir_y};
      for (int i = 1; i <= SqrtSteps; i++) begin
        logic [RadW-1:0] b, t;
        b = RadW'(1) << (2 * (SqrtSteps - i));
        t = sq_res_q[i-1] + b;
        if (sq_n_q[i-1] >= t) begin
          sq_n_q[i]   <= sq_n_q[i-1] - t;
          sq_res_q[i] <= (sq_res_q[i-1] >> 1) + b;
        end else begin
          sq_n_q[i]   <= sq_n_q[i-1];
          sq_res_q[i] <= sq_res_q[i-1] >> 1;
        end
        sq_c_q[i] <= sq_c_q[i-1];
      end
    end
  end

  // ---- rounding of the root and offset products ----
  logic                     pr_v_q;
  carry_t                   pr_c_q;
  logic [RadBits-1:0]       root_q;
  logic signed [DivW-1:0]   num_q [4];
  logic [DivW-1:0]          den_q;
  logic                     rt_v_q;
  carry_t                   rt_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q <= 1'b0;
      pr_v_q <= 1'b0;
    end else if (advance_i) begin
      rt_v_q <= sq_v_q[SqrtSteps];
      pr_v_q <= rt_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      root_q <= RadBits'(sq_res_q[SqrtSteps])
              + RadBits'(sq_n_q[SqrtSteps] > sq_res_q[SqrtSteps]);
      rt_c_q <= sq_c_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      logic signed [DivW-1:0] bx, by, ox, oy;
      bx = DivW'(rt_c_q.base_x) <<< ScaleK;
      by = DivW'(rt_c_q.base_y) <<< ScaleK;
      ox = DivW'(rt_c_q.dir_x * $signed({1'b0, root_q}));
      oy = DivW'(rt_c_q.dir_y * $signed({1'b0, root_q}));
      num_q[0] <= bx - ox;
      num_q[1] <= by - oy;
      num_q[2] <= bx + ox;
      num_q[3] <= by + oy;
      den_q    <= DivW'(rt_c_q.dot_ee);
      pr_c_q   <= rt_c_q;
    end
  end

  // ---- restoring dividers, one quotient bit per stage ----
  logic               dv_v_q   [QuotBits+1];
  status_e            dv_st_q  [QuotBits+1];
  logic [DivW-1:0]    dv_den_q [QuotBits+1];
  logic [DivW-1:0]    dv_rem_q [4][QuotBits+1];
  logic [DivW-1:0]    dv_num_q [4][QuotBits+1];
  logic               dv_neg_q [4][QuotBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QuotBits; i++) dv_v_q[i] <= 1'b0;
    end else if (advance_i) begin
      dv_v_q[0] <= pr_v_q;
      for (int i = 1; i <= QuotBits; i++) dv_v_q[i] <= dv_v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      dv_st_q[0]  <= pr_c_q.status;
      dv_den_q[0] <= den_q << 1;
      for (int c = 0; c < 4; c++) begin
        logic [DivW-1:0] mag;
        mag = num_q[c][DivW-1] ? DivW'(-num_q[c]) : DivW'(num_q[c]);
        dv_num_q[c][0] <= (mag << 1) + den_q;
        dv_rem_q[c][0] <= '0;
        dv_neg_q[c][0] <= num_q[c][DivW-1];
      end
      for (int i = 1; i <= QuotBits; i++) begin
        dv_st_q[i]  <= dv_st_q[i-1];
        dv_den_q[i] <= dv_den_q[i-1];
        for (int c = 0; c < 4; c++) begin
          logic [DivW:0] r;
          r = {dv_rem_q[c][i-1], dv_num_q[c][i-1][DivW-1]};
          if (r >= {1'b0, dv_den_q[i-1]}) begin
            dv_rem_q[c][i] <= DivW'(r - {1'b0, dv_den_q[i-1]});
            dv_num_q[c][i] <= {dv_num_q[c][i-1][DivW-2:0], 1'b1};
          end else begin
            dv_rem_q[c][i] <= DivW'(r);
            dv_num_q[c][i] <= {dv_num_q[c][i-1][DivW-2:0], 1'b0};
          end
          dv_neg_q[c][i] <= dv_neg_q[c][i-1];
        end
      end
    end
  end

  // ---- sign, saturation and output register ----
  logic      out_v_q;
  out_item_t out_q;

  function automatic logic [OutBits-1:0] sat_f(input logic [QuotBits-1:0] mag,
                                               input logic neg);
    logic [QuotBits:0] v;
    logic signed [QuotBits:0] s;
    v = {1'b0, mag};
    s = neg ? -$signed(v) : $signed(v);
    if (s > $signed((QuotBits+1)'({1'b0, {(OutBits-1){1'b1}}}))) begin
      return {1'b0, {(OutBits-1){1'b1}}};
    end else if (s < -$signed((QuotBits+1)'({1'b1, {(OutBits-1){1'b0}}}))) begin
      return {1'b1, {(OutBits-1){1'b0}}};
    end
    return OutBits'(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance_i) begin
      out_v_q <= dv_v_q[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      logic [OutBits-1:0] r [4];
      for (int c = 0; c < 4; c++) begin
        r[c] = sat_f(dv_num_q[c][QuotBits][QuotBits-1:0], dv_neg_q[c][QuotBits]);
      end
      out_q.status <= dv_st_q[QuotBits];
      if (dv_st_q[QuotBits] == StatusTwoPoints) begin
        out_q.near_x <= r[0];
        out_q.near_y <= r[1];
        out_q.far_x  <= r[2];
        out_q.far_y  <= r[3];
      end else begin
        out_q.near_x <= '0;
        out_q.near_y <= '0;
        out_q.far_x  <= '0;
        out_q.far_y  <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule : lci_back

`default_nettype wire

>>> rtl/line_circle_intersection_top.sv
// ----------------------------------------------------------------------------
// line_circle_intersection_top: line and circle intersection in exact
// fixed-point arithmetic.
//
// An input transfer on the in channel carries one query: a circle centre and
// radius and two points on a line, all with four fraction bits. For each
// query exactly one output transfer follows on the out channel, in order,
// with a status code and the two crossing points in Q.16.
// The front part forms the dot products and the discriminant over two
// register stages and classifies the query. A four-entry queue decouples it
// from the back part: a square root pipeline (one root bit per stage), a
// root rounding stage, an offset product stage and a restoring divider with
// one quotient bit per stage. An input transfer passes through two front
// stages, the queue, 49 root stages, the rounding and product stages, 68
// divider stages and the output register. Without stalls one query is taken
// every cycle.
// The back pipeline advances only while its output register is free or being
// emptied, so a stalled receiver holds the result steady and the stall backs
// up through the queue to the in channel's ready.
// Reset empties the pipelines and the queue; nothing else needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module line_circle_intersection_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  lci_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lci_pkg::out_item_t out_data_o
);
  import lci_pkg::*;

  logic  front_valid, front_adv;
  job_t  front_job;
  logic  q_full, q_empty, q_push, q_pop;
  job_t  q_job;
  logic  back_adv;

  // Back advances whenever its output is free or being taken. The front
  // advances whenever the queue has room or an entry leaves at the same edge.
  assign back_adv = !out_valid_o || out_ready_i;
  assign q_pop    = back_adv && !q_empty;
  assign front_adv = !q_full || q_pop;
  assign q_push   = front_adv && front_valid;
  assign in_ready_o = front_adv;

  lci_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_data_i),
    .advance_i  (front_adv),
    .out_valid_o(front_valid),
    .out_job_o  (front_job)
  );

  lci_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(front_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .pop_job_o (q_job)
  );

  lci_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_pop),
    .in_job_i   (q_job),
    .advance_i  (back_adv),
    .out_valid_o(out_valid_o),
    .out_item_o (out_data_o)
  );

  // A push never meets a full queue unless an entry leaves at the same edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_push && q_full |-> q_pop)
    else $error("queue overflow");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue underflow");

  // A stalled result keeps its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !out_ready_i |=> $stable(out_data_o.status))
    else $error("result changed while stalled");

endmodule : line_circle_intersection_top

`default_nettype wire
